// ----- sv/first_fit_heap_allocator_top_assert.svh -----
// Assertion macros for the first-fit heap allocator.
// Used by first_fit_heap_allocator_top; expects clk and rst_n in scope.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset
`define FFA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle
`define FFA_ASSERT_IMPLY(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/ffa_pkg.sv -----
// Shared types and constants of the first-fit heap allocator.
// No dependencies; imported by first_fit_heap_allocator_top.
package ffa_pkg;

    localparam int HEAP_BYTES_DEF   = 65536;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int MAX_BLOCKS_DEF   = 256;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOFIT    = 3'd1,
        ST_NONE     = 3'd2,
        ST_BADADDR  = 3'd3,
        ST_BELOW    = 3'd4,
        ST_NOTALLOC = 3'd5,
        ST_FULL     = 3'd6
    } status_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] req_size;
        logic [15:0] addr;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] result_addr;
    } rsp_item_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_F_RD,
        S_F_CHK,
        S_NX_RD,
        S_NX_CHK,
        S_MV_RD,
        S_MV_WR,
        S_DONE
    } state_t;

endpackage

// ----- sv/ffa_stream_if.sv -----
// Valid/ready stream channel carrying one payload per transaction.
// Payload type is given by the instantiating scope.
interface ffa_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- sv/first_fit_heap_allocator_top.sv -----
// First-fit heap allocator: address-ordered block table walked by a sequencer.
// Steps: each table entry scanned takes a read and a check state, each entry shifted on split
// or merge a move read and a move write, then come the neighbor read, final write and result
// load; a result waits in DONE while the output is stalled.
// Throughput: one transaction at a time; req.ready is high only in the idle state.
// Reset: asynchronous for control state; after reset the INIT state writes entry zero, then ready.
`include "first_fit_heap_allocator_top_assert.svh"

module first_fit_heap_allocator_top
    import ffa_pkg::*;
#(
    parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ffa_stream_if.sink   req,
    ffa_stream_if.source rsp
);
    localparam int AW = $clog2(HEAP_BYTES);
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int XW = $clog2(MAX_BLOCKS + 3);
    localparam int EW = 2 * AW + 1;

    typedef struct packed {
        logic [AW-1:0] start;
        logic [AW-1:0] size;
        logic          is_free;
    } entry_t;

    localparam logic [AW-1:0] HDR_A  = AW'(HEADER_BYTES);
    localparam logic [16:0]   HDR_17 = 17'(HEADER_BYTES);
    localparam logic [16:0]   HEAP_17 = 17'(HEAP_BYTES);
    localparam logic [XW-1:0] MAXB_X = XW'(MAX_BLOCKS);

    state_t    state_reg, state_next;
    logic [XW-1:0] count_reg, count_next;
    logic [XW-1:0] idx_reg, idx_next;
    logic [XW-1:0] src_reg, src_next;
    logic [XW-1:0] dst_reg, dst_next;
    logic [XW-1:0] pos_reg, pos_next;
    logic      ins_reg, ins_next;
    logic      first_reg, first_next;
    logic      prev_ok_reg, prev_ok_next;
    logic      nxt_ok_reg, nxt_ok_next;
    req_item_t item_reg, item_next;
    entry_t    prev_reg, prev_next;
    entry_t    cur_reg, cur_next;
    entry_t    rest_reg, rest_next;
    logic [2:0]  st_reg, st_next;
    logic [15:0] res_reg, res_next;
    logic      rsp_valid_reg, rsp_valid_next;
    rsp_item_t rsp_reg, rsp_next;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;
    logic [IW-1:0] rd_addr;
    logic [EW-1:0] rd_raw;
    entry_t        rd_e;

    logic [16:0] diff;
    logic [15:0] hdr_addr;

    assign rd_e = entry_t'(rd_raw);
    assign diff = 17'(rd_e.size) - {1'b0, item_reg.req_size};
    assign hdr_addr = item_reg.addr - HDR_17[15:0];

    ffa_mem #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (EW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (EW'(wr_data)),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            count_reg     <= XW'(1);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Hold working registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        pos_reg     <= pos_next;
        ins_reg     <= ins_next;
        first_reg   <= first_next;
        prev_ok_reg <= prev_ok_next;
        nxt_ok_reg  <= nxt_ok_next;
        item_reg    <= item_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        rest_reg    <= rest_next;
        st_reg      <= st_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    // Sequence the table walk, splits, merges and shifts
    always_comb
    begin
        logic nf;
        logic pf;
        logic matched;
        logic first_now;
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        pos_next       = pos_reg;
        ins_next       = ins_reg;
        first_next     = first_reg;
        prev_ok_next   = prev_ok_reg;
        nxt_ok_next    = nxt_ok_reg;
        item_next      = item_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        rest_next      = rest_reg;
        st_next        = st_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        wr_en          = 1'b0;
        wr_addr        = idx_reg[IW-1:0];
        wr_data        = rd_e;
        rd_addr        = idx_reg[IW-1:0];
        nf             = 1'b0;
        pf             = 1'b0;
        matched        = 1'b0;
        first_now      = first_reg;

        unique case (state_reg)
            S_INIT:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = '{start: '0, size: AW'(HEAP_BYTES - HEADER_BYTES), is_free: 1'b1};
                count_next = XW'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    item_next    = req.payload;
                    idx_next     = '0;
                    first_next   = 1'b0;
                    prev_ok_next = 1'b0;
                    res_next     = '0;
                    state_next   = (req.payload.op == OP_ALLOC) ? S_A_RD : S_F_RD;
                end
            end
            S_A_RD:
            begin
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                // Take first free block that fits
                if (rd_e.is_free && !diff[16])
                begin
                    res_next = 16'(17'(rd_e.start) + HDR_17);
                    st_next  = ST_OK;
                    if (diff > HDR_17)
                    begin
                        if (count_reg >= MAXB_X)
                        begin
                            st_next    = ST_FULL;
                            res_next   = '0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_data   = '{start: rd_e.start, size: AW'(item_reg.req_size),
                                          is_free: 1'b0};
                            rest_next = '{start: AW'(17'(rd_e.start) + HDR_17
                                                     + {1'b0, item_reg.req_size}),
                                          size: AW'(diff - HDR_17), is_free: 1'b1};
                            ins_next   = 1'b1;
                            pos_next   = idx_reg + XW'(1);
                            dst_next   = count_reg;
                            src_next   = count_reg - XW'(1);
                            state_next = S_MV_RD;
                        end
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_data    = '{start: rd_e.start, size: rd_e.size, is_free: 1'b0};
                        state_next = S_DONE;
                    end
                end
                else if (idx_reg + XW'(1) == count_reg)
                begin
                    st_next    = ST_NOFIT;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + XW'(1);
                    state_next = S_A_RD;
                end
            end
            S_F_RD:
            begin
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                // Locate first allocated block, check address, then match
                if (!first_reg && !rd_e.is_free)
                begin
                    first_now  = 1'b1;
                    first_next = 1'b1;
                    if ({1'b0, item_reg.addr} < HDR_17 || {1'b0, item_reg.addr} >= HEAP_17)
                    begin
                        st_next    = ST_BADADDR;
                        state_next = S_DONE;
                    end
                    else if (hdr_addr < 16'(rd_e.start))
                    begin
                        st_next    = ST_BELOW;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        matched = (16'(rd_e.start) == hdr_addr);
                    end
                end
                else if (first_reg)
                begin
                    matched = !rd_e.is_free && (16'(rd_e.start) == hdr_addr);
                end

                if (state_next != S_DONE)
                begin
                    if (matched)
                    begin
                        cur_next    = rd_e;
                        nxt_ok_next = (idx_reg + XW'(1) < count_reg);
                        state_next  = S_NX_RD;
                    end
                    else if (idx_reg + XW'(1) == count_reg)
                    begin
                        st_next    = first_now ? ST_NOTALLOC : ST_NONE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        prev_next    = rd_e;
                        prev_ok_next = 1'b1;
                        idx_next     = idx_reg + XW'(1);
                        state_next   = S_F_RD;
                    end
                end
            end
            S_NX_RD:
            begin
                rd_addr    = IW'(idx_reg + XW'(1));
                state_next = S_NX_CHK;
            end
            S_NX_CHK:
            begin
                // Mark free and merge with free neighbors
                nf       = nxt_ok_reg && rd_e.is_free;
                pf       = prev_ok_reg && prev_reg.is_free;
                st_next  = ST_OK;
                wr_en    = 1'b1;
                ins_next = 1'b0;
                if (pf && nf)
                begin
                    wr_addr    = IW'(idx_reg - XW'(1));
                    wr_data    = '{start: prev_reg.start,
                                   size: prev_reg.size + HDR_A + HDR_A + cur_reg.size
                                         + rd_e.size,
                                   is_free: 1'b1};
                    dst_next   = idx_reg;
                    src_next   = idx_reg + XW'(2);
                    state_next = S_MV_RD;
                end
                else if (pf)
                begin
                    wr_addr    = IW'(idx_reg - XW'(1));
                    wr_data    = '{start: prev_reg.start,
                                   size: prev_reg.size + HDR_A + cur_reg.size, is_free: 1'b1};
                    dst_next   = idx_reg;
                    src_next   = idx_reg + XW'(1);
                    state_next = S_MV_RD;
                end
                else if (nf)
                begin
                    wr_data    = '{start: cur_reg.start,
                                   size: cur_reg.size + HDR_A + rd_e.size, is_free: 1'b1};
                    dst_next   = idx_reg + XW'(1);
                    src_next   = idx_reg + XW'(2);
                    state_next = S_MV_RD;
                end
                else
                begin
                    wr_data    = '{start: cur_reg.start, size: cur_reg.size, is_free: 1'b1};
                    state_next = S_DONE;
                end
            end
            S_MV_RD:
            begin
                // Shift entries one at a time through MV_RD and MV_WR, or finish
                rd_addr = src_reg[IW-1:0];
                if (ins_reg && dst_reg == pos_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = dst_reg[IW-1:0];
                    wr_data    = rest_reg;
                    count_next = count_reg + XW'(1);
                    state_next = S_DONE;
                end
                else if (!ins_reg && src_reg >= count_reg)
                begin
                    count_next = dst_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MV_WR;
                end
            end
            S_MV_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = dst_reg[IW-1:0];
                wr_data = rd_e;
                if (ins_reg)
                begin
                    dst_next = dst_reg - XW'(1);
                    src_next = src_reg - XW'(1);
                end
                else
                begin
                    dst_next = dst_reg + XW'(1);
                    src_next = src_reg + XW'(1);
                end
                state_next = S_MV_RD;
            end
            S_DONE:
            begin
                // Load result once the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status: st_reg, result_addr: res_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // Check table occupancy and result consistency
    `FFA_ASSERT_ALWAYS(a_count_range, (count_reg >= XW'(1) && count_reg <= MAXB_X), "block count out of range")
    `FFA_ASSERT_IMPLY(a_fail_zero, (rsp_valid_reg && rsp_reg.status != ST_OK), (rsp_reg.result_addr == '0), "failed result carries an address")
    `FFA_ASSERT_IMPLY(a_free_zero, (state_reg == S_DONE && item_reg.op == OP_FREE), (res_reg == '0), "free produced an address")
endmodule

// ----- sv/ffa_mem.sv -----
// Block table storage: one write port and one registered read port.
// Depends on nothing; instantiated by first_fit_heap_allocator_top.
module ffa_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 33
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end
endmodule
